>>> src/cog_pkg.sv
`timescale 1ns / 1ps

package cog_pkg;

  // Fixed ladder of six legs and seven links
  localparam int NUM_OSC     = 6;
  localparam int IDX_W       = 3;
  localparam int PHASE_W     = 16;
  localparam int NUM_LINKS   = 7;
  localparam int LINK_W      = 3;
  localparam int NUM_ENTRIES = 14;
  localparam int ENTRY_W     = 4;
  localparam logic [ENTRY_W-1:0] LAST_ENTRY = 4'd13;

  // Accumulated sine sum (up to three Q14 terms) and oscillator rate
  localparam int SUM_W  = 18;
  localparam int RATE_W = 18;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_BASE_FREQ = 2'd0;
  localparam logic [1:0] REG_GAIT      = 2'd1;

  localparam logic [15:0] FREQ_RESET = 16'd652;

  // Codes carried in tuser
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  // Gait codes
  localparam logic [1:0] GSEL_NONE        = 2'd0;
  localparam logic [1:0] GSEL_METACHRONAL = 2'd1;
  localparam logic [1:0] GSEL_RIPPLE      = 2'd2;
  localparam logic [1:0] GSEL_TRIPOD      = 2'd3;

  // Sine polynomial constants, Q14
  localparam logic [14:0] QUARTER_TURN = 15'd16384;
  localparam logic [10:0] POLY_C3      = 11'd1160;
  localparam logic [13:0] POLY_C2      = 14'd10512;
  localparam logic [14:0] POLY_C1      = 15'd25736;

  // 65536 / (8 * pi): Q14 sine sum to Q4.12 turns per second
  localparam logic signed [31:0] COUPLING_GAIN  = 32'sd2608;
  localparam logic signed [31:0] COUPLING_ROUND = 32'sd32768;
  localparam logic signed [34:0] STEP_ROUND     = 35'sd2048;

  // One half-link seen from one oscillator: entries are grouped by oscillator
  typedef struct packed {
    logic [IDX_W-1:0]  self_idx;
    logic [IDX_W-1:0]  nbr_idx;
    logic [LINK_W-1:0] link;
    logic              is_a;   // self is the first end of the link
    logic              last;   // last neighbor of this oscillator
  } cog_entry_t;

  function automatic cog_entry_t cog_entry(input logic [ENTRY_W-1:0] e);
    cog_entry_t r;
    case (e)
      4'd0:    r = '{3'd0, 3'd1, 3'd0, 1'b1, 1'b0};
      4'd1:    r = '{3'd0, 3'd2, 3'd1, 1'b1, 1'b1};
      4'd2:    r = '{3'd1, 3'd0, 3'd0, 1'b0, 1'b0};
      4'd3:    r = '{3'd1, 3'd3, 3'd2, 1'b1, 1'b1};
      4'd4:    r = '{3'd2, 3'd0, 3'd1, 1'b0, 1'b0};
      4'd5:    r = '{3'd2, 3'd3, 3'd3, 1'b1, 1'b0};
      4'd6:    r = '{3'd2, 3'd4, 3'd4, 1'b1, 1'b1};
      4'd7:    r = '{3'd3, 3'd1, 3'd2, 1'b0, 1'b0};
      4'd8:    r = '{3'd3, 3'd2, 3'd3, 1'b0, 1'b0};
      4'd9:    r = '{3'd3, 3'd5, 3'd5, 1'b1, 1'b1};
      4'd10:   r = '{3'd4, 3'd2, 3'd4, 1'b0, 1'b0};
      4'd11:   r = '{3'd4, 3'd5, 3'd6, 1'b1, 1'b1};
      4'd12:   r = '{3'd5, 3'd3, 3'd5, 1'b0, 1'b0};
      4'd13:   r = '{3'd5, 3'd4, 3'd6, 1'b0, 1'b1};
      default: r = '{3'd0, 3'd0, 3'd0, 1'b0, 1'b1};
    endcase
    return r;
  endfunction

  // Link phase bias in 16-bit turns per gait
  function automatic logic [PHASE_W-1:0] gait_bias(input logic [1:0] gait,
                                                   input logic [LINK_W-1:0] link);
    logic [PHASE_W-1:0] r;
    logic               end_link;
    end_link = (link == 3'd0) || (link == 3'd3) || (link == 3'd6);
    case (gait)
      GSEL_NONE:        r = 16'd0;
      GSEL_METACHRONAL: r = end_link ? 16'd32768 : 16'd10923;
      GSEL_RIPPLE:      r = end_link ? 16'd32768 : 16'd16384;
      GSEL_TRIPOD:      r = 16'd32768;
      default:          r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/cog_ram.sv
`timescale 1ns / 1ps

module cog_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/coupled_oscillator_gait_generator.sv
`timescale 1ns / 1ps
// Six-leg coupled oscillator pattern generator, phases kept in a two-bank RAM.
// Load beat: written in idle, then the six phases are read out; no new beat is taken until
// the result is raised. Advance beat: per oscillator ST_RDSELF and ST_GETSELF, then ST_ANGLE
// and ST_M1..ST_M4 for each half-link through the polynomial sequencer, then ST_RATE and
// ST_STEP; then readout. No new beat is taken until the result is raised; a waiting result holds readout.
// Reset (rst, synchronous): a clearing pass zeroes the phase bank before s_tready.
module coupled_oscillator_gait_generator #(
  parameter int SINE_ADDR_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // time_step[15:0], osc_index[18:16], load_value[34:19]
  input  logic        s_tuser,   // action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // phase_leg1[15:0] .. phase_leg6[95:80]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int PW     = cog_pkg::PHASE_W;
  localparam int IW     = cog_pkg::IDX_W;
  localparam int ADDR_W = IW + 1;
  localparam int DEPTH  = 2 ** ADDR_W;
  // keep only the top SINE_ADDR_BITS of the sine angle
  localparam logic [PW-1:0] ANGLE_MASK = ~PW'((1 << (PW - SINE_ADDR_BITS)) - 1);
  localparam logic [IW-1:0] NUM_OSC_I  = IW'(cog_pkg::NUM_OSC);

  // sequencer states
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RDSELF  = 4'd2;
  localparam logic [3:0] ST_GETSELF = 4'd3;
  localparam logic [3:0] ST_ANGLE   = 4'd4;
  localparam logic [3:0] ST_M1      = 4'd5;
  localparam logic [3:0] ST_M2      = 4'd6;
  localparam logic [3:0] ST_M3      = 4'd7;
  localparam logic [3:0] ST_M4      = 4'd8;
  localparam logic [3:0] ST_RATE    = 4'd9;
  localparam logic [3:0] ST_STEP    = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  // configuration registers
  logic signed [15:0] base_frequency;
  logic [1:0]         gait_select;

  // control
  logic [3:0]                      state;
  logic [cog_pkg::ENTRY_W-1:0]     entry;
  logic                            bank;     // bank holding the current phases
  logic [IW-1:0]                   cnt;

  // datapath registers
  logic [PW-1:0]                   dt;
  logic [PW-1:0]                   pself;
  logic [14:0]                     t;
  logic                            neg;
  logic [14:0]                     t2;
  logic [13:0]                     inner;
  logic [14:0]                     mid;
  logic signed [cog_pkg::SUM_W-1:0]  sum;
  logic signed [cog_pkg::RATE_W-1:0] rate;
  logic [PW-1:0]                   out_ph [cog_pkg::NUM_OSC];

  // RAM ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [PW-1:0]     wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [PW-1:0]     rd_data;

  // combinational helpers
  cog_pkg::cog_entry_t ent;
  cog_pkg::cog_entry_t ent_next;
  logic                s_accept;
  logic                in_action;
  logic [PW-1:0]       in_dt;
  logic [IW-1:0]       in_idx;
  logic [PW-1:0]       in_load;
  logic [PW-1:0]       bias;
  logic [PW-1:0]       angle;
  logic [13:0]         ang_r;
  logic [29:0]         prod_sq;
  logic [25:0]         prod_c3;
  logic [28:0]         prod_inner;
  logic [29:0]         prod_sin;
  logic [15:0]         sin_mag;
  logic signed [cog_pkg::SUM_W-1:0] sin_val;
  logic signed [31:0]  cpl_prod;
  logic signed [31:0]  cpl_round;
  logic signed [34:0]  step_prod;
  logic signed [34:0]  step_round;
  logic [PW-1:0]       new_phase;

  assign in_action = s_tuser;
  assign in_dt     = s_tdata[15:0];
  assign in_idx    = s_tdata[18:16];
  assign in_load   = s_tdata[34:19];

  assign s_tready  = (state == ST_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign ent      = cog_pkg::cog_entry(entry);
  assign ent_next = cog_pkg::cog_entry(entry + 1'b1);

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= signed'(cog_pkg::FREQ_RESET);
      gait_select    <= cog_pkg::GSEL_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cog_pkg::REG_BASE_FREQ: base_frequency <= signed'(cfg_data);
        cog_pkg::REG_GAIT:      gait_select    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Phase store: bank bit on top, oscillator index below. Advance reads the current
  // bank and writes the other, so all oscillators see the old phases; flip at the end.
  cog_ram #(
    .WIDTH(PW),
    .DEPTH(DEPTH)
  ) u_phase_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Angle seen from self: p_nbr - p_self - b for the first link end, + b for the other.
  assign bias  = cog_pkg::gait_bias(gait_select, ent.link);
  assign angle = (ent.is_a ? (rd_data - pself - bias) : (rd_data - pself + bias))
                 & ANGLE_MASK;
  assign ang_r = angle[13:0];

  // Sine polynomial: one product per state, registered before the next.
  assign prod_sq    = t * t;
  assign prod_c3    = t2 * cog_pkg::POLY_C3;
  assign prod_inner = t2 * inner;
  assign prod_sin   = t * mid;
  assign sin_mag    = prod_sin[29:14];
  assign sin_val    = neg ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});

  // Coupling sum to Q4.12 rate, rounded, floor via arithmetic shift.
  assign cpl_prod  = sum * cog_pkg::COUPLING_GAIN;
  assign cpl_round = cpl_prod + cog_pkg::COUPLING_ROUND;

  // Phase step: rate * dt rounded, taken modulo one turn.
  assign step_prod  = rate * $signed({1'b0, dt});
  assign step_round = step_prod + cog_pkg::STEP_ROUND;
  assign new_phase  = pself + step_round[27:12];

  // Write port: clearing pass, loads, and new phases into the idle bank.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {bank, ent.self_idx};
    wr_data = new_phase;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, cnt};
        wr_data = '0;
      end
      ST_IDLE: begin
        wr_en   = s_accept && (in_action == cog_pkg::ACT_LOAD) && (in_idx < NUM_OSC_I);
        wr_addr = {bank, in_idx};
        wr_data = in_load;
      end
      ST_STEP: begin
        wr_en   = 1'b1;
        wr_addr = {~bank, ent.self_idx};
        wr_data = new_phase;
      end
      default: ;
    endcase
  end

  // Read port: self phase, then neighbor phases; the next neighbor is fetched
  // during the last polynomial state so its data is ready at ST_ANGLE.
  always_comb begin
    case (state)
      ST_RDSELF:  rd_addr = {bank, ent.self_idx};
      ST_GETSELF: rd_addr = {bank, ent.nbr_idx};
      ST_M4:      rd_addr = {bank, ent_next.nbr_idx};
      ST_OUT:     rd_addr = {bank, cnt};
      default:    rd_addr = {bank, ent.self_idx};
    endcase
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      entry    <= '0;
      bank     <= 1'b0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once the beat is taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (cnt == NUM_OSC_I - 1'b1) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            cnt <= '0;
            if (in_action == cog_pkg::ACT_LOAD) begin
              state <= ST_OUT;
            end else begin
              dt    <= in_dt;
              entry <= '0;
              sum   <= '0;
              state <= ST_RDSELF;
            end
          end
        end
        ST_RDSELF: begin
          state <= ST_GETSELF;
        end
        ST_GETSELF: begin
          pself <= rd_data;
          state <= ST_ANGLE;
        end
        ST_ANGLE: begin
          // fold the quadrant into a quarter-turn argument
          t     <= angle[14] ? (cog_pkg::QUARTER_TURN - {1'b0, ang_r}) : {1'b0, ang_r};
          neg   <= angle[15];
          state <= ST_M1;
        end
        ST_M1: begin
          t2    <= prod_sq[28:14];
          state <= ST_M2;
        end
        ST_M2: begin
          inner <= cog_pkg::POLY_C2 - {3'b000, prod_c3[24:14]};
          state <= ST_M3;
        end
        ST_M3: begin
          mid   <= cog_pkg::POLY_C1 - prod_inner[28:14];
          state <= ST_M4;
        end
        ST_M4: begin
          sum <= sum + sin_val;
          if (ent.last) begin
            state <= ST_RATE;
          end else begin
            entry <= entry + 1'b1;
            state <= ST_ANGLE;
          end
        end
        ST_RATE: begin
          // coupling term is signed: sign-extend it like the base frequency
          rate  <= cog_pkg::RATE_W'(base_frequency) +
                   cog_pkg::RATE_W'($signed(cpl_round[31:16]));
          state <= ST_STEP;
        end
        ST_STEP: begin
          sum <= '0;
          if (entry == cog_pkg::LAST_ENTRY) begin
            bank  <= ~bank;
            cnt   <= '0;
            state <= ST_OUT;
          end else begin
            entry <= entry + 1'b1;
            state <= ST_RDSELF;
          end
        end
        ST_OUT: begin
          // hold until the previous result is gone, then read all six phases out
          if (!(cnt == '0 && m_tvalid)) begin
            if (cnt != '0) begin
              out_ph[cnt - 1'b1] <= rd_data;
            end
            if (cnt == NUM_OSC_I) begin
              m_tvalid <= 1'b1;
              cnt      <= '0;
              state    <= ST_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < cog_pkg::NUM_OSC; i++) begin
      m_tdata[i*PW +: PW] = out_ph[i];
    end
  end

`ifndef SYNTHESIS
  // bank flips only at the end of the last oscillator update
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> ($past(state) == ST_STEP &&
                               $past(entry) == cog_pkg::LAST_ENTRY))
    else $error("phase bank flipped outside the final step");

  // new phases never land in the bank still being read
  a_step_bank: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> (wr_en && wr_addr[ADDR_W-1] != bank))
    else $error("advance wrote into the current phase bank");

  // a result appears only from the readout sequence
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUT && $past(cnt) == NUM_OSC_I))
    else $error("result raised outside readout");

  // at most three Q14 sine terms per oscillator
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RATE) |-> (sum <= 18'sd49152 && sum >= -18'sd49152))
    else $error("coupling sum out of range");
`endif

endmodule

>>> test/gait_phase_checker.sv
`timescale 1ns / 1ps

module gait_phase_checker #(
  parameter int SINE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          outstanding,
  output int          results_seen
);

  localparam int DROP = 16 - SINE_BITS;
  localparam int PW   = cog_pkg::PHASE_W;

  typedef logic [cog_pkg::NUM_OSC-1:0][PW-1:0] leg_phases_t;

  // Ends of the seven ladder links, link 0 in the lowest slot
  localparam logic [6:0][2:0] LINK_LO = {3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0};
  localparam logic [6:0][2:0] LINK_HI = {3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1};
  // Side-link bias per gait; the rungs (links 0, 3, 6) take half a turn in every real gait
  localparam logic [3:0][15:0] SIDE_BIAS = {16'd32768, 16'd16384, 16'd10923, 16'd0};

  leg_phases_t        leg_phase;
  logic signed [15:0] freq_q412;
  logic [1:0]         gait;
  leg_phases_t        awaited_phases[$];

  function automatic logic [15:0] link_bias(input logic [1:0] g, input int k);
    if (g == cog_pkg::GSEL_NONE) return 16'd0;
    if (k == 0 || k == 3 || k == 6) return 16'd32768;
    return SIDE_BIAS[g];
  endfunction

  // Polynomial sine of a 16-bit angle, signed Q14
  function automatic int wave_q14(input logic [15:0] angle);
    logic [15:0] coarse;
    int unsigned r, t, t2, inner, mid, mag;
    coarse = (angle >> DROP) << DROP;
    r      = coarse[13:0];
    t      = coarse[14] ? 32'd16384 - r : r;
    t2     = (t * t) >> 14;
    inner  = 32'd10512 - ((t2 * 32'd1160) >> 14);
    mid    = 32'd25736 - ((t2 * inner) >> 14);
    mag    = (t * mid) >> 14;
    return coarse[15] ? -int'(mag) : int'(mag);
  endfunction

  function automatic leg_phases_t step_oscillators(input leg_phases_t cur,
                                                   input logic signed [15:0] freq,
                                                   input logic [1:0] g,
                                                   input logic [15:0] dt);
    int                 wave_sum [cog_pkg::NUM_OSC];
    leg_phases_t        nxt;
    logic [15:0]        bias, pa, pb, ang;
    logic signed [63:0] rate, prod;
    for (int i = 0; i < cog_pkg::NUM_OSC; i++) wave_sum[i] = 0;
    for (int k = 0; k < cog_pkg::NUM_LINKS; k++) begin
      bias = link_bias(g, k);
      pa   = cur[LINK_LO[k]];
      pb   = cur[LINK_HI[k]];
      ang  = pb - pa - bias;
      wave_sum[LINK_LO[k]] += wave_q14(ang);
      ang  = pa - pb + bias;
      wave_sum[LINK_HI[k]] += wave_q14(ang);
    end
    for (int i = 0; i < cog_pkg::NUM_OSC; i++) begin
      rate   = 64'(freq) + ((64'sd2608 * wave_sum[i] + 64'sd32768) >>> 16);
      prod   = rate * $signed({48'd0, dt}) + 64'sd2048;
      nxt[i] = cur[i] + prod[27:12];
    end
    return nxt;
  endfunction

  always @(posedge clk) begin : watch
    leg_phases_t want;
    logic        bad;
    logic [2:0]  idx;
    if (rst) begin
      leg_phase    = '0;
      freq_q412    = cog_pkg::FREQ_RESET;
      gait         = cog_pkg::GSEL_NONE;
      awaited_phases.delete();
      fails        = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cog_pkg::REG_BASE_FREQ: freq_q412 = cfg_data;
          cog_pkg::REG_GAIT:      gait      = cfg_data[1:0];
          default:                ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (awaited_phases.size() == 0) begin
          $error("phase beat with nothing pending: %h", m_tdata);
          fails++;
        end else begin
          want = awaited_phases.pop_front();
          bad  = 1'b0;
          for (int i = 0; i < cog_pkg::NUM_OSC; i++) begin
            if (m_tdata[PW*i +: PW] !== want[i]) begin
              $error("phase_leg%0d: expected %0d, actual %0d", i + 1, want[i],
                     m_tdata[PW*i +: PW]);
              bad = 1'b1;
            end
          end
          if (bad) fails++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == cog_pkg::ACT_LOAD) begin
          idx = s_tdata[18:16];
          if (idx < cog_pkg::NUM_OSC) leg_phase[idx] = s_tdata[34:19];
        end else begin
          leg_phase = step_oscillators(leg_phase, freq_q412, gait, s_tdata[15:0]);
        end
        awaited_phases.push_back(leg_phase);
      end
    end
    outstanding = awaited_phases.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the six-leg gait generator. A checker beside the block
// predicts every phase beat; this module only feeds beats, config writes and
// back-pressure, and decides pass or fail at the end.
module testbench;

  localparam int SINE_BITS      = 8;
  // A long receiver hold comes on top of the time an advance takes
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 72;

  // Receiver behaviors
  localparam int SINK_OPEN    = 0;
  localparam int SINK_COIN    = 1;
  localparam int SINK_SPARSE  = 2;
  localparam int SINK_PATTERN = 3;

  localparam logic ADV  = cog_pkg::ACT_ADVANCE;
  localparam logic LOAD = cog_pkg::ACT_LOAD;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;   // time_step[15:0], osc_index[18:16], load_value[34:19]
  logic        s_tuser   = cog_pkg::ACT_ADVANCE;  // action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [95:0] m_tdata;          // phase_leg1[15:0] .. phase_leg6[95:80]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = cog_pkg::REG_BASE_FREQ;
  logic [15:0] cfg_data  = '0;

  int fails;
  int outstanding;
  int results_seen;

  always #5 clk = ~clk;

  coupled_oscillator_gait_generator #(
    .SINE_ADDR_BITS(SINE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  gait_phase_checker #(
    .SINE_BITS(SINE_BITS)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fails       (fails),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  // Offer one beat from a falling edge and return at the falling edge after it is taken.
  // Valid stays high on return so back-to-back beats need no second assignment.
  task automatic offer_beat(input logic act, input logic [15:0] dt,
                            input logic [2:0] idx, input logic [15:0] ld);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {5'd0, ld, idx, dt};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid for a pause whose length the caller gives (n >= 1)
  task automatic pause_sender(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold until every predicted beat has come back
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Register writes happen only with the input idle and nothing in flight
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: switch between stall patterns, and hold off twice for a long stretch
  // while the sender keeps offering, so the block backs up into its input.
  initial begin : result_sink
    int mode, mode_left, hold_left, holds_done;
    mode       = SINK_OPEN;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < 2 &&
          results_seen >= (holds_done == 0 ? 150 : 420)) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(SINK_OPEN, SINK_PATTERN);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   m_tready <= 1'b1;
          SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no handshake on any channel
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    int          left, burst, pick;
    logic [15:0] freq;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero step, longest step, loads of every slot including the
    // two indexes past the last leg, which must leave the phases alone.
    offer_beat(ADV,  16'h0000, 3'd7, 16'hFFFF);
    offer_beat(ADV,  16'hFFFF, 3'd0, 16'h0000);
    offer_beat(LOAD, 16'hFFFF, 3'd0, 16'hFFFF);
    offer_beat(LOAD, 16'h0000, 3'd1, 16'h0000);
    offer_beat(LOAD, 16'h1234, 3'd2, 16'hAAAA);
    offer_beat(LOAD, 16'h0000, 3'd3, 16'h5555);
    offer_beat(LOAD, 16'h0000, 3'd4, 16'h8000);
    offer_beat(LOAD, 16'h0000, 3'd5, 16'h7FFF);
    offer_beat(LOAD, 16'h0000, 3'd6, 16'h1234);
    offer_beat(LOAD, 16'hFFFF, 3'd7, 16'hFFFF);
    offer_beat(ADV,  16'h0800, 3'd5, 16'hFFFF);
    offer_beat(ADV,  16'hFFFF, 3'd0, 16'h0000);

    // Most negative frequency, tripod; anti-phase pair on the first rung
    pause_sender(1);
    write_reg(cog_pkg::REG_BASE_FREQ, 16'h8000);
    write_reg(cog_pkg::REG_GAIT, 16'(cog_pkg::GSEL_TRIPOD));
    offer_beat(ADV,  16'hFFFF, 3'd2, 16'h5A5A);
    offer_beat(LOAD, 16'h0000, 3'd0, 16'h0000);
    offer_beat(LOAD, 16'h0000, 3'd1, 16'h8000);
    offer_beat(ADV,  16'h1000, 3'd0, 16'h0000);

    // Most positive frequency, metachronal
    pause_sender(1);
    write_reg(cog_pkg::REG_BASE_FREQ, 16'h7FFF);
    write_reg(cog_pkg::REG_GAIT, 16'(cog_pkg::GSEL_METACHRONAL));
    offer_beat(ADV, 16'hFFFF, 3'd0, 16'h0000);
    offer_beat(ADV, 16'h0001, 3'd0, 16'h0000);

    // Coupling alone, ripple
    pause_sender(1);
    write_reg(cog_pkg::REG_BASE_FREQ, 16'h0000);
    write_reg(cog_pkg::REG_GAIT, 16'(cog_pkg::GSEL_RIPPLE));
    offer_beat(ADV, 16'hFFFF, 3'd0, 16'h0000);
    offer_beat(ADV, 16'h8000, 3'd0, 16'h0000);

    // Random phases: each runs under its own settings, starts from six fresh
    // phases, then mixes steps with the odd reload in bursts.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 5)
        0:       freq = 16'h8000;
        1:       freq = 16'h7FFF;
        2:       freq = 16'h0000;
        3:       freq = cog_pkg::FREQ_RESET;
        default: freq = 16'($urandom_range(0, 65535));
      endcase
      pause_sender(1);
      write_reg(cog_pkg::REG_BASE_FREQ, freq);
      write_reg(cog_pkg::REG_GAIT, 16'(p % 4));
      for (int i = 0; i < cog_pkg::NUM_OSC; i++)
        offer_beat(LOAD, 16'($urandom_range(0, 65535)), 3'(i),
                   16'($urandom_range(0, 65535)));
      left = ITEMS_PER_PHASE;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) begin
          pick = $urandom_range(0, 9);
          if (pick < 2)
            offer_beat(LOAD, 16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                       16'($urandom_range(0, 65535)));
          else
            offer_beat(ADV,
                       pick < 6 ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 65535)),
                       3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
          left--;
        end
        // Gap after the burst: none, a short one, or a full drain of the block
        pick = $urandom_range(0, 9);
        if (pick >= 4) pause_sender($urandom_range(1, 30));
        if (pick == 9) settle();
      end
    end

    pause_sender(1);
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0 && outstanding == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
